// File: design/mcl_pkg.sv
// mcl_pkg: shared types and codes for the mutex / condition-variable lock manager.
// No dependencies.
package mcl_pkg;

   localparam int unsigned CMD_W = 2;
   localparam int unsigned TID_W = 4;
   localparam int unsigned MID_W = 3;
   localparam int unsigned CID_W = 3;
   localparam int unsigned STS_W = 2;

   // sizing of the lock manager; field widths above are tied to these
   localparam int unsigned NUM_THREADS  = 16;
   localparam int unsigned NUM_MUTEXES  = 8;
   localparam int unsigned NUM_CONDVARS = 8;
   localparam int unsigned QUEUE_DEPTH  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOCK   = 2'd0,
      CMD_UNLOCK = 2'd1,
      CMD_WAIT   = 2'd2,
      CMD_SIGNAL = 2'd3
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK         = 2'd0,
      STS_FULL       = 2'd1,
      STS_WAIT_FREE  = 2'd2,
      STS_NO_WAITER  = 2'd3
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [TID_W-1:0] thread_id;
      logic [MID_W-1:0] mutex_id;
      logic [CID_W-1:0] condvar_id;
   } req_type;

   typedef struct packed {
      logic             granted;
      logic             blocked_valid;
      logic [TID_W-1:0] blocked_thread;
      logic             owner_valid;
      logic [TID_W-1:0] owner_thread;
      logic [MID_W-1:0] owner_mutex;
      logic [STS_W-1:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_READ   = 2'd1,
      ST_LOCK2  = 2'd2
   } state_type;

endpackage

// File: design/mutex_condvar_lock_manager_core.sv
// mutex_condvar_lock_manager_core: top level of the lock manager.
// Depends on mcl_pkg and mcl_ram.
//
// One command is taken while busy is low and start is high. Lock, unlock and
// wait finish in ST_READ; signal, when it pops a waiter, goes on to ST_LOCK2,
// as the waiter queues live in two RAMs with registered read and the mutex it
// locks or queues on is known only from the popped entry. The result appears on
// rsp_* for one cycle with rsp_valid and cannot be stalled; busy stays high
// from acceptance up to and including the result cycle's predecessor, so the
// next command may be given in the cycle the result is shown. Per-mutex and
// per-condition heads, counts, busy bits and owners are small register files
// cleared by reset; queue payload RAMs are undefined until written and are
// only read inside a queue's live region, so no clearing pass is needed.
module mutex_condvar_lock_manager_core
   import mcl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned MW  = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
   localparam int unsigned KW  = (NUM_CONDVARS > 1) ? $clog2(NUM_CONDVARS) : 1;
   localparam int unsigned MAW = MW + QW;
   localparam int unsigned KAW = KW + QW;
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

   // per-mutex and per-condition control
   logic          mbusy_ff  [NUM_MUTEXES];
   logic [TID_W-1:0] mowner_ff [NUM_MUTEXES];
   logic [QW-1:0] mhead_ff  [NUM_MUTEXES];
   logic [CW-1:0] mcount_ff [NUM_MUTEXES];
   logic [QW-1:0] chead_ff  [NUM_CONDVARS];
   logic [CW-1:0] ccount_ff [NUM_CONDVARS];

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // RAM ports
   logic                 mq_we, cq_we;
   logic [MAW-1:0]       mq_wa, mq_ra;
   logic [KAW-1:0]       cq_wa, cq_ra;
   logic [TID_W-1:0]     mq_wd, mq_rd;
   logic [TID_W+MID_W-1:0] cq_wd, cq_rd;

   mcl_ram #(.WIDTH(TID_W), .DEPTH(NUM_MUTEXES * QUEUE_DEPTH)) u_mq (
      .clock(clock), .wr_en(mq_we), .wr_addr(mq_wa), .wr_data(mq_wd),
      .rd_addr(mq_ra), .rd_data(mq_rd));

   mcl_ram #(.WIDTH(TID_W + MID_W), .DEPTH(NUM_CONDVARS * QUEUE_DEPTH)) u_cq (
      .clock(clock), .wr_en(cq_we), .wr_addr(cq_wa), .wr_data(cq_wd),
      .rd_addr(cq_ra), .rd_data(cq_rd));

   // index helpers (out-of-range ids are filtered before use)
   logic [MW-1:0] m_idx, sm_idx, in_m_idx;
   logic [KW-1:0] c_idx, in_c_idx;
   logic          m_ok, c_ok, t_ok, sm_ok;
   logic [TID_W-1:0] st;
   logic [MID_W-1:0] sm;

   assign m_idx = MW'(req_ff.mutex_id);
   assign c_idx = KW'(req_ff.condvar_id);
   assign in_m_idx = MW'(req_data.mutex_id);
   assign in_c_idx = KW'(req_data.condvar_id);
   assign m_ok  = 32'(req_ff.mutex_id) < NUM_MUTEXES;
   assign c_ok  = 32'(req_ff.condvar_id) < NUM_CONDVARS;
   assign t_ok  = 32'(req_ff.thread_id) < NUM_THREADS;
   assign st    = cq_rd[TID_W+MID_W-1:MID_W];
   assign sm    = cq_rd[MID_W-1:0];
   assign sm_idx = MW'(sm);
   assign sm_ok = 32'(sm) < NUM_MUTEXES;

   // control register updates computed combinationally
   logic          m_we, c_we;
   logic [MW-1:0] mw_idx;
   logic          mw_busy;
   logic [TID_W-1:0] mw_owner;
   logic [QW-1:0] mw_head;
   logic [CW-1:0] mw_count;
   logic [QW-1:0] cw_head;
   logic [CW-1:0] cw_count;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      mq_we = 1'b0; mq_wa = '0; mq_wd = '0;
      cq_we = 1'b0; cq_wa = '0; cq_wd = '0;
      // read the head slots of the addressed queues
      mq_ra = {m_idx, mhead_ff[m_idx]};
      cq_ra = {c_idx, chead_ff[c_idx]};
      m_we = 1'b0; c_we = 1'b0;
      mw_idx = m_idx;
      mw_busy = mbusy_ff[m_idx]; mw_owner = mowner_ff[m_idx];
      mw_head = mhead_ff[m_idx]; mw_count = mcount_ff[m_idx];
      cw_head = chead_ff[c_idx]; cw_count = ccount_ff[c_idx];
      case (state_ff)
         ST_IDLE: begin
            // address the incoming command's heads so they are read at acceptance
            mq_ra = {in_m_idx, mhead_ff[in_m_idx]};
            cq_ra = {in_c_idx, chead_ff[in_c_idx]};
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // head data of both queues is now on the RAM outputs
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (cmd_type'(req_ff.command))
               CMD_LOCK: begin
                  if (t_ok && m_ok) begin
                     if (mbusy_ff[m_idx]) begin
                        if (mcount_ff[m_idx] >= FULL) begin
                           rsp_in.status = STS_FULL;
                        end else begin
                           mq_we = 1'b1;
                           mq_wa = {m_idx, QW'(mhead_ff[m_idx] + QW'(mcount_ff[m_idx]))};
                           mq_wd = req_ff.thread_id;
                           m_we = 1'b1;
                           mw_count = mcount_ff[m_idx] + 1'b1;
                           rsp_in.blocked_valid  = 1'b1;
                           rsp_in.blocked_thread = req_ff.thread_id;
                        end
                     end else begin
                        m_we = 1'b1;
                        mw_busy = 1'b1; mw_owner = req_ff.thread_id;
                        rsp_in.granted      = 1'b1;
                        rsp_in.owner_valid  = 1'b1;
                        rsp_in.owner_thread = req_ff.thread_id;
                        rsp_in.owner_mutex  = req_ff.mutex_id;
                     end
                  end
               end
               CMD_UNLOCK, CMD_WAIT: begin
                  logic go_unlock;
                  go_unlock = 1'b0;
                  if (cmd_type'(req_ff.command) == CMD_UNLOCK) begin
                     go_unlock = m_ok;
                  end else if (m_ok && c_ok) begin
                     if (!mbusy_ff[m_idx]) begin
                        rsp_in.status = STS_WAIT_FREE;
                     end else if (ccount_ff[c_idx] >= FULL) begin
                        rsp_in.status = STS_FULL;
                     end else begin
                        cq_we = 1'b1;
                        cq_wa = {c_idx, QW'(chead_ff[c_idx] + QW'(ccount_ff[c_idx]))};
                        cq_wd = {mowner_ff[m_idx], req_ff.mutex_id};
                        c_we = 1'b1;
                        cw_count = ccount_ff[c_idx] + 1'b1;
                        rsp_in.blocked_valid  = 1'b1;
                        rsp_in.blocked_thread = mowner_ff[m_idx];
                        go_unlock = 1'b1;
                     end
                  end
                  if (go_unlock) begin
                     m_we = 1'b1;
                     if (mcount_ff[m_idx] == '0) begin
                        mw_busy = 1'b0; mw_owner = '0;
                     end else begin
                        mw_busy  = 1'b1; mw_owner = mq_rd;
                        mw_head  = QW'(mhead_ff[m_idx] + 1'b1);
                        mw_count = mcount_ff[m_idx] - 1'b1;
                        rsp_in.owner_valid  = 1'b1;
                        rsp_in.owner_thread = mq_rd;
                        rsp_in.owner_mutex  = req_ff.mutex_id;
                     end
                  end
               end
               default: begin
                  // signal: pop condition head, then lock or queue on its mutex next cycle
                  if (c_ok) begin
                     if (ccount_ff[c_idx] == '0) begin
                        rsp_in.status = STS_NO_WAITER;
                     end else begin
                        c_we = 1'b1;
                        cw_head  = QW'(chead_ff[c_idx] + 1'b1);
                        cw_count = ccount_ff[c_idx] - 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in = ST_LOCK2;
                     end
                  end
               end
            endcase
         end
         ST_LOCK2: begin
            // cq_rd holds the popped (thread, mutex) pair
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            mw_idx   = sm_idx;
            mw_busy  = mbusy_ff[sm_idx]; mw_owner = mowner_ff[sm_idx];
            mw_head  = mhead_ff[sm_idx]; mw_count = mcount_ff[sm_idx];
            if (sm_ok) begin
               if (mbusy_ff[sm_idx]) begin
                  if (mcount_ff[sm_idx] >= FULL) begin
                     rsp_in.status = STS_FULL;
                  end else begin
                     mq_we = 1'b1;
                     mq_wa = {sm_idx, QW'(mhead_ff[sm_idx] + QW'(mcount_ff[sm_idx]))};
                     mq_wd = st;
                     m_we = 1'b1;
                     mw_count = mcount_ff[sm_idx] + 1'b1;
                     rsp_in.blocked_valid  = 1'b1;
                     rsp_in.blocked_thread = st;
                  end
               end else begin
                  m_we = 1'b1;
                  mw_busy = 1'b1; mw_owner = st;
                  rsp_in.owner_valid  = 1'b1;
                  rsp_in.owner_thread = st;
                  rsp_in.owner_mutex  = sm;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_MUTEXES; i++) begin
            mbusy_ff[i] <= 1'b0; mowner_ff[i] <= '0;
            mhead_ff[i] <= '0;   mcount_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_CONDVARS; i++) begin
            chead_ff[i] <= '0; ccount_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (m_we) begin
            mbusy_ff[mw_idx]  <= mw_busy;
            mowner_ff[mw_idx] <= mw_owner;
            mhead_ff[mw_idx]  <= mw_head;
            mcount_ff[mw_idx] <= mw_count;
         end
         if (c_we) begin
            chead_ff[c_idx]  <= cw_head;
            ccount_ff[c_idx] <= cw_count;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end
endmodule

// File: design/mcl_ram.sv
// mcl_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mcl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
